// ===== rtl/csem_pkg.sv =====
// shared constants for the counting semaphore table
// field widths, operation and status codes, default table sizes
// no dependencies
package csem_pkg;

    localparam int MODE_W = 2;
    localparam int KEY_W  = 32;
    localparam int CNT_W  = 16;
    localparam int REQ_W  = 4;
    localparam int STAT_W = 2;

    localparam int DEF_NUM_SEMS   = 32;
    localparam int DEF_WAIT_DEPTH = 16;

    localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_INIT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WAIT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POST = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_FREE    = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND  = 2'd2;
    localparam logic [STAT_W-1:0] ST_QUEUE_FULL = 2'd3;

endpackage

// ===== rtl/counting_semaphore_table.sv =====
// counting semaphore table: key/count/queue entries with per-entry waiter fifo
// depends on csem_pkg for widths and codes
//
// Usage
//   Request channel: present i_mode, i_sem_key, i_init_value and i_requester
//   with start high; the beat is taken at the rising edge where start is high
//   and busy is low. busy stays high until the request is finished.
//   Result channel: o_done is high for exactly one cycle and carries o_status,
//   o_blocked, o_woke_valid and o_woke_requester. The receiver cannot stall
//   the block; a result beat is taken at the edge that ends its cycle.
// Timing
//   The table is searched one entry a cycle by a single compare unit fed by
//   the registered read port of the entry memory. The search stops at the
//   target of the request (a free entry for init, the lowest used entry with
//   the key otherwise); o_done then rises after the update step, and after
//   one more waiter-memory read for a post that wakes a waiter. A failed
//   search ends at the last entry; an unknown mode is answered with no search.
//   One request is in flight at a time; busy falls in the cycle o_done is shown.
// Reset
//   i_rst_n low clears the used flags, the sequencer and the result strobe.
//   The entry and waiter memories are not cleared: an entry's contents are only
//   used once its init has written it, and only queued waiter slots are read.
module counting_semaphore_table #(
    parameter int NUM_SEMS   = csem_pkg::DEF_NUM_SEMS,
    parameter int WAIT_DEPTH = csem_pkg::DEF_WAIT_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [csem_pkg::MODE_W-1:0]   i_mode,
    input  logic [csem_pkg::KEY_W-1:0]    i_sem_key,
    input  logic [csem_pkg::CNT_W-1:0]    i_init_value,
    input  logic [csem_pkg::REQ_W-1:0]    i_requester,
    output logic                          o_done,
    output logic [csem_pkg::STAT_W-1:0]   o_status,
    output logic                          o_blocked,
    output logic                          o_woke_valid,
    output logic [csem_pkg::REQ_W-1:0]    o_woke_requester
);

    localparam int IW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int CW = $clog2(NUM_SEMS + 1);
    localparam int HW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int FW = $clog2(WAIT_DEPTH + 1);
    localparam int WN = NUM_SEMS * WAIT_DEPTH;
    localparam int AW = (WN > 1) ? $clog2(WN) : 1;

    typedef struct packed {
        logic [csem_pkg::KEY_W-1:0] key;
        logic [csem_pkg::CNT_W-1:0] count;
        logic [HW-1:0]              head;
        logic [FW-1:0]              fill;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_EXEC = 4'b0100,
        S_WAKE = 4'b1000
    } t_state;

    // memories
    t_entry                     r_ent_mem [NUM_SEMS];
    logic [csem_pkg::REQ_W-1:0] r_wt_mem  [WN];

    // control
    t_state                      r_state;
    logic [NUM_SEMS-1:0]         r_used;
    logic [CW-1:0]               r_idx;
    logic                        r_q_vld;
    logic [IW-1:0]               r_q_idx;
    t_entry                      r_q_ent;
    logic [csem_pkg::REQ_W-1:0]  r_wt_q;

    // captured request
    logic [csem_pkg::MODE_W-1:0] r_mode;
    logic [csem_pkg::KEY_W-1:0]  r_key;
    logic [csem_pkg::CNT_W-1:0]  r_ival;
    logic [csem_pkg::REQ_W-1:0]  r_req;

    // result
    logic                        r_done;
    logic [csem_pkg::STAT_W-1:0] r_status;
    logic                        r_blocked;
    logic                        r_woke_valid;
    logic [csem_pkg::REQ_W-1:0]  r_woke_req;

    // datapath
    logic                        hit;
    logic                        last;
    logic                        scan_rd;
    logic [HW:0]                 slot_sum;
    logic [HW-1:0]               wr_slot;
    logic [HW-1:0]               head_inc;
    logic [AW-1:0]               base;
    logic [AW-1:0]               wr_addr;
    logic [AW-1:0]               rd_addr;
    t_entry                      n_ent;
    logic                        ent_we;
    logic                        wt_we;
    logic                        wt_re;
    logic                        go_wake;
    logic [csem_pkg::STAT_W-1:0] n_status;
    logic                        n_blocked;

    // shared compare unit: one entry per cycle
    always_comb begin
        if (r_mode == csem_pkg::MODE_INIT) begin
            hit = r_q_vld && !r_used[r_q_idx];
        end else begin
            hit = r_q_vld && r_used[r_q_idx] && (r_q_ent.key == r_key);
        end
        last    = r_q_vld && (r_q_idx == IW'(NUM_SEMS - 1));
        scan_rd = (r_state == S_SCAN) && !hit && (r_idx < CW'(NUM_SEMS));
    end

    // ring arithmetic for the waiter fifo of the selected entry
    always_comb begin
        slot_sum = (HW + 1)'(r_q_ent.head) + (HW + 1)'(r_q_ent.fill);
        if (slot_sum >= (HW + 1)'(WAIT_DEPTH)) begin
            wr_slot = HW'(slot_sum - (HW + 1)'(WAIT_DEPTH));
        end else begin
            wr_slot = HW'(slot_sum);
        end
        if (r_q_ent.head == HW'(WAIT_DEPTH - 1)) begin
            head_inc = '0;
        end else begin
            head_inc = r_q_ent.head + HW'(1);
        end
        base    = AW'(r_q_idx) * AW'(WAIT_DEPTH);
        wr_addr = base + AW'(wr_slot);
        rd_addr = base + AW'(r_q_ent.head);
    end

    // read-modify-write of the selected entry
    always_comb begin
        n_ent     = r_q_ent;
        ent_we    = 1'b0;
        wt_we     = 1'b0;
        wt_re     = 1'b0;
        go_wake   = 1'b0;
        n_status  = csem_pkg::ST_OK;
        n_blocked = 1'b0;
        if (r_state == S_EXEC) begin
            case (r_mode)
                csem_pkg::MODE_INIT: begin
                    n_ent.key   = r_key;
                    n_ent.count = r_ival;
                    n_ent.head  = '0;
                    n_ent.fill  = '0;
                    ent_we      = 1'b1;
                end
                csem_pkg::MODE_WAIT: begin
                    if (r_q_ent.count != '0) begin
                        n_ent.count = r_q_ent.count - 1'b1;
                        ent_we      = 1'b1;
                    end else if (r_q_ent.fill == FW'(WAIT_DEPTH)) begin
                        n_status = csem_pkg::ST_QUEUE_FULL;
                    end else begin
                        n_ent.fill = r_q_ent.fill + FW'(1);
                        ent_we     = 1'b1;
                        wt_we      = 1'b1;
                        n_blocked  = 1'b1;
                    end
                end
                csem_pkg::MODE_POST: begin
                    if (r_q_ent.fill != '0) begin
                        n_ent.head = head_inc;
                        n_ent.fill = r_q_ent.fill - FW'(1);
                        ent_we     = 1'b1;
                        wt_re      = 1'b1;
                        go_wake    = 1'b1;
                    end else if (r_q_ent.count != csem_pkg::COUNT_MAX) begin
                        n_ent.count = r_q_ent.count + 1'b1;
                        ent_we      = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            r_ent_mem[r_q_idx] <= n_ent;
        end
        if (scan_rd) begin
            r_q_ent <= r_ent_mem[r_idx[IW-1:0]];
        end
    end

    // waiter memory
    always_ff @(posedge i_clk) begin
        if (wt_we) begin
            r_wt_mem[wr_addr] <= r_req;
        end
        if (wt_re) begin
            r_wt_q <= r_wt_mem[rd_addr];
        end
    end

    // request capture and scan index of the registered read
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_mode <= i_mode;
            r_key  <= i_sem_key;
            r_ival <= i_init_value;
            r_req  <= i_requester;
        end
        if (scan_rd) begin
            r_q_idx <= r_idx[IW-1:0];
        end
        r_woke_req <= (r_state == S_WAKE) ? r_wt_q : '0;
        if (r_state == S_EXEC) begin
            r_status  <= n_status;
            r_blocked <= n_blocked;
        end else if (r_state == S_SCAN) begin
            r_status  <= (r_mode == csem_pkg::MODE_INIT) ?
                         csem_pkg::ST_NO_FREE : csem_pkg::ST_NOT_FOUND;
            r_blocked <= 1'b0;
        end else begin
            r_status  <= csem_pkg::ST_OK;
            r_blocked <= 1'b0;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_used       <= '0;
            r_idx        <= '0;
            r_q_vld      <= 1'b0;
            r_done       <= 1'b0;
            r_woke_valid <= 1'b0;
        end else begin
            r_done       <= 1'b0;
            r_woke_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_idx   <= '0;
                    r_q_vld <= 1'b0;
                    if (start) begin
                        if (i_mode == csem_pkg::MODE_INIT || i_mode == csem_pkg::MODE_WAIT
                            || i_mode == csem_pkg::MODE_POST) begin
                            r_state <= S_SCAN;
                        end else begin
                            // unknown operation: answer ok, touch nothing
                            r_done <= 1'b1;
                        end
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        r_state <= S_EXEC;
                    end else if (last) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_q_vld <= scan_rd;
                        if (scan_rd) begin
                            r_idx <= r_idx + CW'(1);
                        end
                    end
                end
                S_EXEC: begin
                    if (r_mode == csem_pkg::MODE_INIT) begin
                        r_used[r_q_idx] <= 1'b1;
                    end
                    if (go_wake) begin
                        r_state <= S_WAKE;
                    end else begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_WAKE: begin
                    r_done       <= 1'b1;
                    r_woke_valid <= 1'b1;
                    r_state      <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_blocked        = r_blocked;
    assign o_woke_valid     = r_woke_valid;
    assign o_woke_requester = r_woke_req;

    // a result beat is only shown once the sequencer is back at rest
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !busy)
        else $error("result beat while busy");

    // an accepted request either starts work or answers at once
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || r_done))
        else $error("accepted beat lost");

    // a failed request neither blocks nor wakes
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_status != csem_pkg::ST_OK) |-> (!r_blocked && !r_woke_valid))
        else $error("side effect reported on failed request");

    // a waiter is only popped from a non-empty queue of a used entry
    a_pop_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wt_re |-> (r_used[r_q_idx] && r_q_ent.fill != '0))
        else $error("pop from empty or unused queue");

    // woken requester only flagged after the wake step
    a_wake_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_woke_valid |-> ($past(r_state) == S_WAKE && r_done))
        else $error("wake reported outside the wake step");

endmodule
